// ===== src/base_relocation_table_walker_defines.svh =====
// Assertion macros for the base relocation table walker.
// Used by the top level; the macros expect clk and arst_n in scope.
`ifndef BASE_RELOCATION_TABLE_WALKER_DEFINES_SVH
`define BASE_RELOCATION_TABLE_WALKER_DEFINES_SVH
`ifndef SYNTHESIS
`define BRTW_ASSERT_IMPLY(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
	else $error("assertion failed: same-cycle implication");
`define BRTW_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
	else $error("assertion failed: next-cycle implication");
`else
`define BRTW_ASSERT_IMPLY(lbl, a, b)
`define BRTW_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== src/brtw_pkg.sv =====
// Shared types, codes and decode functions of the relocation table walker.
// No dependencies.
package brtw_pkg;

	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIPPED    = 2'd2;

	localparam logic [2:0] ST_ENTRY    = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_BAD_SIZE = 3'd2;
	localparam logic [2:0] ST_BEYOND   = 3'd3;
	localparam logic [2:0] ST_ILLEGAL  = 3'd4;
	localparam logic [2:0] ST_STRIPPED = 3'd5;

	typedef struct packed {
		logic [32:0] addr;
		logic [3:0]  kind;
		logic [2:0]  status;
		logic        last;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Bytes patched by an entry type; zero for skipped and illegal types.
	function automatic logic [3:0] patch_width(input logic [3:0] kind);
		logic [3:0] w;
		case (kind)
			4'd1, 4'd2, 4'd4: w = 4'd2;
			4'd3:             w = 4'd4;
			4'd10:            w = 4'd8;
			default:          w = 4'd0;
		endcase
		return w;
	endfunction

	function automatic logic kind_legal(input logic [3:0] kind);
		logic ok;
		case (kind)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd10: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

// ===== src/brtw_front.sv =====
// Front end of the walker: configuration registers and the per-halfword parser.
// Depends on brtw_pkg; produces result records for the queue.
module brtw_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr,
	input  logic [brtw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [brtw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            accept,
	input  logic [15:0]                     word,
	output logic                            rec_push,
	output brtw_pkg::rec_t                  rec
);
	import brtw_pkg::*;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_HDR0  = 3'd1;
	localparam logic [2:0] PH_HDR1  = 3'd2;
	localparam logic [2:0] PH_HDR2  = 3'd3;
	localparam logic [2:0] PH_HDR3  = 3'd4;
	localparam logic [2:0] PH_ENTRY = 3'd5;
	localparam logic [2:0] PH_HALT  = 3'd6;

	logic [2:0]  phase_q, phase_d;
	logic [31:0] page_q, page_d;
	logic [15:0] half_q, half_d;
	logic [30:0] entries_q, entries_d;
	logic [31:0] left_q, left_d;
	logic [31:0] image_q;
	logic        strip_q;

	logic [31:0] bsize;
	logic [31:0] bsize_m8;
	logic [31:0] rem;
	logic [32:0] addr;
	logic [3:0]  kind;
	logic        end_walk;

	assign bsize    = {word, half_q};
	assign bsize_m8 = bsize - 32'd8;
	assign rem      = left_q - bsize;
	assign addr     = {1'b0, page_q} + {21'b0, word[11:0]};
	assign kind     = word[15:12];
	assign end_walk = (entries_q == 31'd1) && (left_q == 32'd0);

	always_comb begin
		phase_d   = phase_q;
		page_d    = page_q;
		half_d    = half_q;
		entries_d = entries_q;
		left_d    = left_q;
		rec_push  = 1'b0;
		rec       = '0;
		if (accept) begin
			case (phase_q)
				PH_START: begin
					if (strip_q || left_q == 32'd0) begin
						rec_push   = 1'b1;
						rec.status = ST_STRIPPED;
						rec.last   = 1'b1;
						phase_d    = PH_HALT;
					end else begin
						page_d  = {16'b0, word};
						phase_d = PH_HDR1;
					end
				end
				PH_HDR0: begin
					page_d  = {16'b0, word};
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					page_d  = {word, page_q[15:0]};
					phase_d = PH_HDR2;
				end
				PH_HDR2: begin
					half_d  = word;
					phase_d = PH_HDR3;
				end
				PH_HDR3: begin
					if (bsize < 32'd8 || bsize > left_q) begin
						rec_push   = 1'b1;
						rec.status = ST_BAD_SIZE;
						rec.last   = 1'b1;
						phase_d    = PH_HALT;
					end else begin
						left_d    = rem;
						entries_d = bsize_m8[31:1];
						if (bsize_m8[31:1] == 31'd0) begin
							if (rem == 32'd0) begin
								rec_push   = 1'b1;
								rec.status = ST_DONE;
								rec.last   = 1'b1;
								phase_d    = PH_HALT;
							end else begin
								phase_d = PH_HDR0;
							end
						end else begin
							phase_d = PH_ENTRY;
						end
					end
				end
				PH_ENTRY: begin
					// The range check covers skipped types as well.
					if (addr > {1'b0, image_q} || !kind_legal(kind)) begin
						rec_push   = 1'b1;
						rec.addr   = addr;
						rec.kind   = kind;
						rec.status = (addr > {1'b0, image_q}) ? ST_BEYOND : ST_ILLEGAL;
						rec.last   = 1'b1;
						phase_d    = PH_HALT;
					end else begin
						entries_d = entries_q - 31'd1;
						if (end_walk) begin
							phase_d = PH_HALT;
						end else if (entries_q == 31'd1) begin
							phase_d = PH_HDR0;
						end
						if (patch_width(kind) != 4'd0) begin
							rec_push   = 1'b1;
							rec.addr   = addr;
							rec.kind   = kind;
							rec.status = ST_ENTRY;
							rec.last   = end_walk;
						end else if (end_walk) begin
							rec_push   = 1'b1;
							rec.status = ST_DONE;
							rec.last   = 1'b1;
						end
					end
				end
				PH_HALT: begin
					phase_d = PH_HALT;
				end
				default: begin
					phase_d = PH_HALT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			page_q    <= '0;
			half_q    <= '0;
			entries_q <= '0;
			left_q    <= '0;
			image_q   <= '0;
			strip_q   <= 1'b0;
		end else if (cfg_wr) begin
			// Writing the table size rearms the walk.
			case (cfg_index)
				REG_TABLE_BYTES: begin
					left_q    <= cfg_data;
					phase_q   <= PH_START;
					page_q    <= '0;
					half_q    <= '0;
					entries_q <= '0;
				end
				REG_IMAGE_SIZE: image_q <= cfg_data;
				REG_STRIPPED:   strip_q <= cfg_data[0];
				default: ;
			endcase
		end else begin
			phase_q   <= phase_d;
			page_q    <= page_d;
			half_q    <= half_d;
			entries_q <= entries_d;
			left_q    <= left_d;
		end
	end

endmodule

// ===== src/brtw_queue.sv =====
// Short queue of result records between the parser and the output stage.
// Depends on brtw_pkg for the record and status types.
module brtw_queue #(
	parameter int DEPTH = brtw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  brtw_pkg::rec_t    push_rec,
	input  logic              pop,
	output brtw_pkg::rec_t    head,
	output brtw_pkg::q_stat_t stat
);
	import brtw_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rec_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/brtw_back.sv =====
// Output stage: takes records from the queue, adds the patch width and
// holds the result until it is popped. Depends on brtw_pkg.
module brtw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  brtw_pkg::q_stat_t q_stat,
	input  brtw_pkg::rec_t    head,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic [32:0]       reloc_addr,
	output logic [3:0]        reloc_kind,
	output logic [3:0]        patch_bytes,
	output logic [2:0]        status,
	output logic              last
);
	import brtw_pkg::*;

	logic valid_q;

	// A new record moves in when the register is free or its transfer completes.
	assign q_pop = !q_stat.empty && (!valid_q || pop);
	assign empty = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			reloc_addr  <= head.addr;
			reloc_kind  <= head.kind;
			patch_bytes <= (head.status == ST_ENTRY) ? patch_width(head.kind) : 4'd0;
			status      <= head.status;
			last        <= head.last;
		end
	end

endmodule

// ===== src/base_relocation_table_walker.sv =====
// Base relocation table walker, top level: parser, result queue, output stage.
// Throughput: one halfword per cycle while the queue has room; the parser decides each word
// combinationally and writes its record into the queue at the edge that transfers the word;
// the output register loads it once free or popped. Input stalls only on a full queue.
// Reset (arst_n low, asynchronous): walk at its start, registers zero, queue and output empty.
`include "base_relocation_table_walker_defines.svh"
module base_relocation_table_walker #(
	parameter int QUEUE_DEPTH = brtw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr,
	input  logic [brtw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [brtw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            push,
	output logic                            full,
	input  logic [15:0]                     word,
	output logic                            empty,
	input  logic                            pop,
	output logic [32:0]                     reloc_addr,
	output logic [3:0]                      reloc_kind,
	output logic [3:0]                      patch_bytes,
	output logic [2:0]                      status,
	output logic                            last
);
	import brtw_pkg::*;

	logic    accept;
	logic    rec_push;
	rec_t    rec;
	rec_t    head;
	q_stat_t q_stat;
	logic    q_pop;

	assign full   = q_stat.full;
	assign accept = push && !full;

	brtw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.word     (word),
		.rec_push (rec_push),
		.rec      (rec)
	);

	brtw_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (rec_push),
		.push_rec(rec),
		.pop     (q_pop),
		.head    (head),
		.stat    (q_stat)
	);

	brtw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head       (head),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.reloc_addr (reloc_addr),
		.reloc_kind (reloc_kind),
		.patch_bytes(patch_bytes),
		.status     (status),
		.last       (last)
	);

	// A record is only produced for a word that was transferred into the parser.
	`BRTW_ASSERT_IMPLY(a_push_has_room, rec_push, accept && !q_stat.full)
	// After the final record the parser stays silent until it is rearmed.
	`BRTW_ASSERT_NEXT(a_silent_after_last, rec_push && rec.last, !rec_push)
	// A waiting record reaches an empty output register in the next cycle.
	`BRTW_ASSERT_NEXT(a_output_fills, !q_stat.empty && empty, !empty)

endmodule

// ===== tb/sv/base_relocation_table_walker_checker.sv =====
`timescale 1ns / 1ps
// Checker for the base relocation table walker: shared test types, and a module that
// follows the configuration, input and result channels, predicts every result and compares.
// Depends on brtw_pkg for register indexes and status codes.
package brtw_test_pkg;

	typedef enum logic [3:0] {
		KIND_ABSOLUTE  = 4'd0,
		KIND_HIGH      = 4'd1,
		KIND_LOW       = 4'd2,
		KIND_HIGHLOW   = 4'd3,
		KIND_HIGHADJ   = 4'd4,
		KIND_RESERVED6 = 4'd6,
		KIND_RESERVED7 = 4'd7,
		KIND_DIR64     = 4'd10,
		KIND_UNDEFINED = 4'd15
	} reloc_kind_e;

	typedef struct packed {
		logic [32:0] addr;
		logic [3:0]  kind;
		logic [3:0]  patch;
		logic [2:0]  code;
		logic        last;
	} reloc_result_t;

endpackage

module base_relocation_table_walker_checker
	import brtw_pkg::*;
	import brtw_test_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	input  logic                  full,
	input  logic [15:0]           word,
	input  logic                  empty,
	input  logic                  pop,
	input  logic [32:0]           reloc_addr,
	input  logic [3:0]            reloc_kind,
	input  logic [3:0]            patch_bytes,
	input  logic [2:0]            status,
	input  logic                  last,
	output int                    outstanding,
	output int                    fail_count
);

	typedef enum logic [2:0] {
		WALK_START,
		HDR_PAGE_LO,
		HDR_PAGE_HI,
		HDR_SIZE_LO,
		HDR_SIZE_HI,
		WALK_ENTRY,
		WALK_HALTED
	} walk_phase_e;

	logic [31:0]   image_size = '0;
	logic          relocs_stripped = 1'b0;
	walk_phase_e   phase = WALK_START;
	logic [31:0]   page_addr = '0;
	logic [15:0]   size_lo = '0;
	logic [30:0]   entries_left = '0;
	logic [31:0]   bytes_left = '0;

	reloc_result_t relocs_due[$];
	reloc_result_t oldest_due, prediction;
	int            due_count = 0;
	int            mismatches = 0;

	assign outstanding = due_count;
	assign fail_count  = mismatches;

	// Every error, empty-table and done result ends the walk.
	function automatic reloc_result_t closing_result(input logic [32:0] addr,
			input logic [3:0] kind, input logic [2:0] code);
		reloc_result_t r;
		phase  = WALK_HALTED;
		r.addr = addr;
		r.kind = kind;
		r.patch = 4'd0;
		r.code = code;
		r.last = 1'b1;
		return r;
	endfunction

	// Advances the walk by one halfword; returns 1 when that halfword yields a result.
	function automatic bit walk_step(input logic [15:0] w, output reloc_result_t r);
		logic [31:0] block_size;
		logic [32:0] addr;
		logic [3:0]  kind;
		logic [3:0]  width;
		bit          end_block, end_walk;
		r = '0;
		case (phase)
			WALK_START: begin
				if (relocs_stripped || bytes_left == 32'd0) begin
					r = closing_result(33'd0, 4'd0, ST_STRIPPED);
					return 1'b1;
				end
				page_addr = {16'h0000, w};
				phase = HDR_PAGE_HI;
			end
			HDR_PAGE_LO: begin
				page_addr = {16'h0000, w};
				phase = HDR_PAGE_HI;
			end
			HDR_PAGE_HI: begin
				page_addr[31:16] = w;
				phase = HDR_SIZE_LO;
			end
			HDR_SIZE_LO: begin
				size_lo = w;
				phase = HDR_SIZE_HI;
			end
			HDR_SIZE_HI: begin
				block_size = {w, size_lo};
				if (block_size < 32'd8 || block_size > bytes_left) begin
					r = closing_result(33'd0, 4'd0, ST_BAD_SIZE);
					return 1'b1;
				end
				bytes_left = bytes_left - block_size;
				// An odd size still charges its full length against the table.
				entries_left = 31'((block_size - 32'd8) >> 1);
				if (entries_left == 31'd0) begin
					if (bytes_left == 32'd0) begin
						r = closing_result(33'd0, 4'd0, ST_DONE);
						return 1'b1;
					end
					phase = HDR_PAGE_LO;
				end else begin
					phase = WALK_ENTRY;
				end
			end
			WALK_ENTRY: begin
				kind = w[15:12];
				addr = {1'b0, page_addr} + {21'd0, w[11:0]};
				// The range check applies to skipped types as well.
				if (addr > {1'b0, image_size}) begin
					r = closing_result(addr, kind, ST_BEYOND);
					return 1'b1;
				end
				case (kind)
					KIND_HIGH, KIND_LOW, KIND_HIGHADJ: width = 4'd2;
					KIND_HIGHLOW: width = 4'd4;
					KIND_DIR64: width = 4'd8;
					KIND_ABSOLUTE, KIND_RESERVED6, KIND_RESERVED7: width = 4'd0;
					default: begin
						r = closing_result(addr, kind, ST_ILLEGAL);
						return 1'b1;
					end
				endcase
				entries_left = entries_left - 31'd1;
				end_block = (entries_left == 31'd0);
				end_walk = end_block && (bytes_left == 32'd0);
				if (end_walk) begin
					phase = WALK_HALTED;
				end else if (end_block) begin
					phase = HDR_PAGE_LO;
				end
				if (width != 4'd0) begin
					r.addr = addr;
					r.kind = kind;
					r.patch = width;
					r.code = ST_ENTRY;
					r.last = end_walk;
					return 1'b1;
				end
				if (end_walk) begin
					r = closing_result(33'd0, 4'd0, ST_DONE);
					return 1'b1;
				end
			end
			default: begin
				phase = WALK_HALTED;
			end
		endcase
		return 1'b0;
	endfunction

	task automatic check_field(input string name, input logic [32:0] expected,
			input logic [32:0] actual);
		if (actual !== expected) begin
			mismatches++;
			if (mismatches <= 100) begin
				$error("%s: expected %0h, actual %0h", name, expected, actual);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size = '0;
			relocs_stripped = 1'b0;
			phase = WALK_START;
			page_addr = '0;
			size_lo = '0;
			entries_left = '0;
			bytes_left = '0;
			relocs_due.delete();
			mismatches = 0;
			due_count <= 0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					REG_TABLE_BYTES: begin
						bytes_left = cfg_data;
						phase = WALK_START;
						page_addr = '0;
						size_lo = '0;
						entries_left = '0;
					end
					REG_IMAGE_SIZE: image_size = cfg_data;
					REG_STRIPPED: relocs_stripped = cfg_data[0];
					default: ;
				endcase
			end
			// A result leaves the block only after its record has passed the queue and the output register, so the
			// transfer out is matched before this cycle's prediction is queued.
			if (pop && !empty) begin
				if (relocs_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 100) begin
						$error("result with no prediction waiting: reloc_addr %0h status %0d",
							reloc_addr, status);
					end
				end else begin
					oldest_due = relocs_due.pop_front();
					check_field("reloc_addr", oldest_due.addr, reloc_addr);
					check_field("reloc_kind", oldest_due.kind, reloc_kind);
					check_field("patch_bytes", oldest_due.patch, patch_bytes);
					check_field("status", oldest_due.code, status);
					check_field("last", oldest_due.last, last);
				end
			end
			if (push && !full) begin
				if (walk_step(word, prediction)) begin
					relocs_due = {relocs_due, prediction};
				end
			end
			due_count <= relocs_due.size();
		end
	end

endmodule

// ===== tb/sv/base_relocation_table_walker_test.sv =====
`timescale 1ns / 1ps
// Top of the base relocation table walker testbench: clock, reset, directory stimulus,
// configuration writes, result pacing, watchdog and verdict.
// Depends on brtw_pkg, the checker file and the walker itself.
module base_relocation_table_walker_test;
	import brtw_pkg::*;
	import brtw_test_pkg::*;

	localparam int ITEM_TARGET    = 1550;
	localparam int SETTLE_CYCLES  = 6;
	localparam int WATCHDOG_LIMIT = 5000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  push = 1'b0;
	logic                  full;
	logic [15:0]           word = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [32:0]           reloc_addr;
	logic [3:0]            reloc_kind;
	logic [3:0]            patch_bytes;
	logic [2:0]            status;
	logic                  last;

	int outstanding, fail_count;
	int send_idle_pct = 25;
	int pop_stall_pct = 73;
	int items = 0;
	int stall_cycles = 0;

	logic [15:0] dir_words[$];
	reloc_kind_e defined_kinds[8] = '{KIND_ABSOLUTE, KIND_HIGH, KIND_LOW, KIND_HIGHLOW,
		KIND_HIGHADJ, KIND_RESERVED6, KIND_RESERVED7, KIND_DIR64};

	base_relocation_table_walker dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full), .word(word),
		.empty(empty), .pop(pop),
		.reloc_addr(reloc_addr), .reloc_kind(reloc_kind), .patch_bytes(patch_bytes),
		.status(status), .last(last)
	);

	base_relocation_table_walker_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full), .word(word),
		.empty(empty), .pop(pop),
		.reloc_addr(reloc_addr), .reloc_kind(reloc_kind), .patch_bytes(patch_bytes),
		.status(status), .last(last),
		.outstanding(outstanding), .fail_count(fail_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	// Any transfer on either side counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_wr <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send(input logic [15:0] w);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		push <= 1'b1;
		word <= w;
		do @(posedge clk); while (full);
	endtask

	// Waits until every predicted result has been transferred, then lets any halfword
	// that yields nothing clear the pipeline.
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic walk_table(input logic [31:0] tbytes, input logic [31:0] img,
			input logic strip, input int count);
		int split;
		split = ($urandom_range(9) == 0) ? int'($urandom_range(dir_words.size() - 1)) : -1;
		drain();
		write_reg(REG_IMAGE_SIZE, img);
		write_reg(REG_STRIPPED, {31'($urandom), strip});
		write_reg(REG_TABLE_BYTES, tbytes);
		foreach (dir_words[i]) begin
			// Rewriting the image size partway must leave the walk where it was.
			if (i == split) begin
				drain();
				write_reg(REG_IMAGE_SIZE, img);
			end
			send(dir_words[i]);
		end
		items += count;
	endtask

	initial begin
		logic [31:0] tbytes, img, page, first_page, block_size;
		logic        strip;
		int          nblk, nent, mode, count;
		int          entry_slots[$];
		logic [3:0]  bad_kind;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the registers at reset the table is empty.
		send(16'hFFFF);
		items++;

		dir_words = {16'h0000};
		walk_table(32'd16, 32'hFFFF_FFFF, 1'b1, 1);

		// One block with every type; the last entry is skipped, so a done status follows.
		dir_words = {16'h5000, 16'h1234, 16'd24, 16'h0000,
			{KIND_HIGH, 12'h000}, {KIND_LOW, 12'h801}, {KIND_HIGHLOW, 12'h7FE},
			{KIND_HIGHADJ, 12'h123}, {KIND_DIR64, 12'hFFF}, {KIND_ABSOLUTE, 12'h456},
			{KIND_RESERVED6, 12'hABC}, {KIND_RESERVED7, 12'h000}};
		walk_table(32'd24, 32'hFFFF_FFFF, 1'b0, dir_words.size());

		dir_words = {16'h0000, 16'h0000, 16'd10, 16'h0000, {KIND_UNDEFINED, 12'hFFF}};
		walk_table(32'd10, 32'hFFFF_FFFF, 1'b0, dir_words.size());

		// The highest page and offset overflow past 32 bits.
		dir_words = {16'hFFFF, 16'hFFFF, 16'd10, 16'h0000, {KIND_DIR64, 12'hFFF}};
		walk_table(32'd10, 32'hFFFF_FFFF, 1'b0, dir_words.size());

		dir_words = {16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};
		walk_table(32'd8, 32'd0, 1'b0, dir_words.size());

		while (items < ITEM_TARGET) begin
			if (items < ITEM_TARGET / 3) begin
				send_idle_pct = 25;
				pop_stall_pct = 73;
			end else if (items < 2 * ITEM_TARGET / 3) begin
				send_idle_pct = 73;
				pop_stall_pct = 25;
			end else begin
				send_idle_pct = 0;
				pop_stall_pct = 0;
			end
			dir_words.delete();
			entry_slots.delete();
			tbytes = '0;
			img = 32'hFFFF_FFFF;
			strip = ($urandom_range(29) == 0);
			mode = $urandom_range(99);
			if (mode < 10) begin
				repeat ($urandom_range(1, 12)) dir_words = {dir_words, 16'($urandom)};
				case ($urandom_range(2))
					0: tbytes = 32'd0;
					1: tbytes = $urandom;
					default: tbytes = $urandom_range(8, 64);
				endcase
				img = $urandom;
			end else begin
				nblk = $urandom_range(1, 3);
				first_page = '0;
				for (int b = 0; b < nblk; b++) begin
					page = $urandom;
					if (b == 0) first_page = page;
					nent = $urandom_range(0, 8);
					block_size = 32'(8 + 2 * nent) + (($urandom_range(9) == 0) ? 32'd1 : 32'd0);
					dir_words = {dir_words, page[15:0], page[31:16],
						block_size[15:0], block_size[31:16]};
					for (int e = 0; e < nent; e++) begin
						entry_slots = {entry_slots, dir_words.size()};
						dir_words = {dir_words,
							{defined_kinds[$urandom_range(7)], 12'($urandom)}};
					end
					tbytes += block_size;
				end
				if (mode >= 85) begin
					case ($urandom_range(4))
						0: tbytes -= $urandom_range(1, 4);
						1: begin
							dir_words[2] = 16'($urandom_range(7));
							dir_words[3] = 16'h0000;
						end
						2: begin
							dir_words[2] = ($urandom_range(1)) ? 16'hFFFF : 16'($urandom);
							dir_words[3] = ($urandom_range(1)) ? 16'hFFFF : 16'($urandom) | 16'h0001;
						end
						3: begin
							if (entry_slots.size() != 0) begin
								do begin
									bad_kind = 4'($urandom);
								end while (bad_kind == KIND_ABSOLUTE || bad_kind == KIND_HIGH ||
									bad_kind == KIND_LOW || bad_kind == KIND_HIGHLOW ||
									bad_kind == KIND_HIGHADJ || bad_kind == KIND_RESERVED6 ||
									bad_kind == KIND_RESERVED7 || bad_kind == KIND_DIR64);
								dir_words[entry_slots[$urandom_range(entry_slots.size() - 1)]][15:12] =
									bad_kind;
							end
						end
						default: begin
							img = ($urandom_range(3) == 0) ? 32'd0 :
								first_page + 32'($urandom_range(0, 8191));
						end
					endcase
				end else if ($urandom_range(29) == 0) begin
					// A table too long to finish; the next rearm abandons it.
					tbytes = 32'hFFFF_FFFF;
				end
			end
			count = dir_words.size();
			if ($urandom_range(4) == 0) begin
				repeat ($urandom_range(1, 3)) dir_words = {dir_words, 16'($urandom)};
			end
			walk_table(tbytes, img, strip, count);
		end

		drain();
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
